@@ hw/rtl/rpec_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpec_pkg
// Shared types and constants for the relative path escape checker.
// ----------------------------------------------------------------------------
package rpec_pkg;

    localparam int unsigned OUT_DEPTH_W = 16;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_DOT1  = 2'd1,
        PH_DOT2  = 2'd2,
        PH_ORD   = 2'd3
    } t_phase;

endpackage

@@ hw/rtl/rpec_intf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpec interfaces
// Valid/ready channels for path bytes in and check results out.
// ----------------------------------------------------------------------------
interface rpec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] path_byte;
    logic       byte_present;
    logic       end_of_path;

    modport source (output valid, output path_byte, output byte_present,
                    output end_of_path, input ready);
    modport sink   (input valid, input path_byte, input byte_present,
                    input end_of_path, output ready);
endinterface

interface rpec_out_if;
    logic                             valid;
    logic                             ready;
    logic                             path_ok;
    logic [rpec_pkg::OUT_DEPTH_W-1:0] final_depth;

    modport source (output valid, output path_ok, output final_depth, input ready);
    modport sink   (input valid, input path_ok, input final_depth, output ready);
endinterface

@@ hw/rtl/relative_path_escape_check_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relative_path_escape_check_core
// Byte-wise scan of a relative path; reports whether it climbs above root.
// ----------------------------------------------------------------------------
//  channel  | dir | transaction
//  ---------+-----+------------------------------------------------------
//  i_in     | in  | one path byte (or none) plus end-of-path flag
//  o_out    | out | path_ok and final_depth, one per end-of-path item
//
//  One byte per cycle while i_in.ready is high: the scan state updates at each accepted transaction.
//  A result appears in the output register the cycle after its end-of-path item is accepted.
//  i_in.ready drops only while a result is held and o_out.ready is low.
//  Synchronous active-low reset returns the scan to component start.
// ----------------------------------------------------------------------------
module relative_path_escape_check_core #(
    parameter int unsigned DEPTH_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rpec_in_if.sink     i_in,
    rpec_out_if.source  o_out
);
    import rpec_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [DEPTH_WIDTH-1:0] r_depth, n_depth;
    logic                   r_escaped, n_escaped;
    logic                   r_out_valid;
    logic                   r_path_ok;
    logic [OUT_DEPTH_W-1:0] r_final_depth;

    logic                   in_acc;
    logic                   do_raise;
    logic                   do_lower;
    logic [DEPTH_WIDTH-1:0] upd_depth;
    logic                   upd_escaped;
    logic [DEPTH_WIDTH+OUT_DEPTH_W-1:0] depth_ext;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    always_comb begin
        n_phase  = r_phase;
        do_raise = 1'b0;
        do_lower = 1'b0;
        if (i_in.byte_present) begin
            case (r_phase)
                PH_START, PH_DOT1: begin
                    if (i_in.path_byte == CH_SLASH) begin
                        n_phase = PH_START;
                    end else if (i_in.path_byte == CH_DOT) begin
                        n_phase = (r_phase == PH_START) ? PH_DOT1 : PH_DOT2;
                    end else begin
                        n_phase  = PH_ORD;
                        do_raise = 1'b1;
                    end
                end
                PH_DOT2: begin
                    if (i_in.path_byte == CH_SLASH) begin
                        n_phase  = PH_START;
                        do_lower = 1'b1;
                    end else begin
                        n_phase  = PH_ORD;
                        do_raise = 1'b1;
                    end
                end
                default: begin
                    if (i_in.path_byte == CH_SLASH) begin
                        n_phase = PH_START;
                    end
                end
            endcase
        end
        // trailing ".." counts as if a slash followed
        if (i_in.end_of_path && n_phase == PH_DOT2) begin
            do_lower = 1'b1;
        end

        upd_depth   = r_depth;
        upd_escaped = r_escaped;
        if (!r_escaped) begin
            if (do_raise && r_depth != {DEPTH_WIDTH{1'b1}}) begin
                upd_depth = r_depth + 1'b1;
            end else if (do_lower) begin
                if (r_depth == '0) begin
                    upd_escaped = 1'b1;
                end else begin
                    upd_depth = r_depth - 1'b1;
                end
            end
        end

        if (i_in.end_of_path) begin
            n_phase   = PH_START;
            n_depth   = '0;
            n_escaped = 1'b0;
        end else begin
            n_depth   = upd_depth;
            n_escaped = upd_escaped;
        end
    end

    assign depth_ext = {{OUT_DEPTH_W{1'b0}}, upd_depth};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_depth     <= '0;
            r_escaped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_phase   <= n_phase;
                r_depth   <= n_depth;
                r_escaped <= n_escaped;
            end
            if (in_acc && i_in.end_of_path) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.end_of_path) begin
            r_path_ok     <= !upd_escaped;
            r_final_depth <= depth_ext[OUT_DEPTH_W-1:0];
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.path_ok     = r_path_ok;
    assign o_out.final_depth = r_final_depth;

    a_result_follows_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.end_of_path |=> r_out_valid)
        else $error("no result after end of path");

    a_scan_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.end_of_path |=> r_phase == PH_START && r_depth == '0 && !r_escaped)
        else $error("scan state not cleared after end of path");

    a_escape_holds_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_escaped && !(in_acc && i_in.end_of_path) |=> $stable(r_depth) && r_escaped)
        else $error("depth moved after escape");

    a_no_lost_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |-> !i_in.ready)
        else $error("input taken while result stalled");

endmodule
